>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the resampler checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define LIRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

>>> rtl/lirs_pkg.sv
// ----------------------------------------------------------------------------
// lirs_pkg
// Widths, limits and types shared by the resampler modules.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int TimeW     = 32;
  localparam int ValW      = 24;
  localparam int StepW     = 20;
  localparam int MaxPoints = 64;
  localparam int CntW      = $clog2(MaxPoints);
  localparam int ProdW     = ValW + TimeW;      // magnitude times offset
  localparam int NumW      = ProdW + 2;         // 2*num + span
  localparam int DenW      = TimeW + 1;         // 2*span
  localparam int QuotW     = ValW;              // quotient never exceeds magnitude
  localparam int NumAxes   = 3;

  localparam logic [StepW-1:0] StepReset = StepW'(11111);

  typedef logic [TimeW-1:0]       time_t;
  typedef logic signed [ValW-1:0] val_t;
  typedef logic [1:0]             axis_t;

endpackage

>>> rtl/lirs_div.sv
// ----------------------------------------------------------------------------
// lirs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lirs_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [lirs_pkg::NumW-1:0]   dividend_i,
  input  logic [lirs_pkg::DenW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [lirs_pkg::QuotW-1:0]  quot_o
);
  import lirs_pkg::*;

  localparam int StepCntW = $clog2(QuotW);

  logic [DenW-1:0]     rem_q;
  logic [QuotW-1:0]    sh_q;
  logic [DenW-1:0]     den_q;
  logic [StepCntW-1:0] cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [DenW:0] trial;
  logic          ge;

  assign trial = {rem_q, sh_q[QuotW-1]};
  assign ge    = (trial >= {1'b0, den_q});

  // The quotient is known to fit QuotW bits, so the upper dividend bits
  // form a partial remainder that is already below the divisor.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      sh_q   <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= dividend_i[QuotW+DenW-1:QuotW];
        sh_q   <= dividend_i[QuotW-1:0];
        den_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
        sh_q  <= {sh_q[QuotW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepCntW'(QuotW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

>>> rtl/linear_interpolating_resampler_core.sv
// ----------------------------------------------------------------------------
// linear_interpolating_resampler_core
// Linear interpolating resampler for timestamped three-axis samples.
//
// Keeps the previous sample; when a newer one arrives, emits points on the
// grid prev_time + k*time_step (k = 0, 1, ...) up to and including
// sample_time, each axis interpolated linearly and rounded to nearest (ties
// away from zero). The final point of a run carries last_point; capped is set
// on it when the run stopped at MaxPoints (64) with grid points left over.
// The first sample, and any sample not later than the stored one, only
// replaces the stored sample and produces no point. A zero time_step acts as
// a step of one. Each point is built in steps: for each of the three axes
// the 24x32 multiply, the divider start and the bit-serial divider (24
// quotient bits plus the hand-off), then the load of the output register.
// The single divider is shared by the three axes. in_stall_o is high from
// the accepted sample until its last point sits in the output register;
// the next point is computed while the current one waits to be taken.
// ----------------------------------------------------------------------------
module linear_interpolating_resampler_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration
  input  logic                        cfg_we_i,
  input  logic [lirs_pkg::StepW-1:0]  cfg_wdata_i,
  // sample input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lirs_pkg::TimeW-1:0]  sample_time_i,
  input  logic signed [lirs_pkg::ValW-1:0] sample_x_i,
  input  logic signed [lirs_pkg::ValW-1:0] sample_y_i,
  input  logic signed [lirs_pkg::ValW-1:0] sample_z_i,
  // point output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lirs_pkg::TimeW-1:0]  point_time_o,
  output logic signed [lirs_pkg::ValW-1:0] point_x_o,
  output logic signed [lirs_pkg::ValW-1:0] point_y_o,
  output logic signed [lirs_pkg::ValW-1:0] point_z_o,
  output logic                        last_point_o,
  output logic                        capped_o
);
  import lirs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_LOAD
  } state_e;

  localparam axis_t AxisLast = axis_t'(NumAxes - 1);

  state_e             state_q;
  logic [StepW-1:0]   time_step_q;
  time_t              prev_time_q;
  val_t               prev_q [NumAxes];
  val_t               new_q  [NumAxes];
  logic               have_prev_q;
  time_t              span_q;
  time_t              off_q;
  logic [CntW-1:0]    cnt_q;
  axis_t              axis_q;
  logic [ProdW-1:0]   prod_q;
  logic               neg_q;
  val_t               res_q  [NumAxes];

  // output register
  logic               out_valid_q;
  time_t              pt_time_q;
  val_t               pt_val_q [NumAxes];
  logic               last_q;
  logic               capped_q;

  // datapath
  val_t               in_val [NumAxes];
  logic signed [ValW:0] diff;
  logic [ValW-1:0]    mag;
  logic [StepW-1:0]   step;
  logic [TimeW:0]     next_off;
  logic               beyond;
  logic               at_cap;
  logic               out_free;
  logic               in_fire;
  logic [NumW-1:0]    div_num;
  logic [DenW-1:0]    div_den;
  logic               div_start;
  logic               div_done;
  logic [QuotW-1:0]   div_quot;
  logic signed [ValW:0] interp;

  assign in_val[0] = sample_x_i;
  assign in_val[1] = sample_y_i;
  assign in_val[2] = sample_z_i;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Treat a zero step as a step of one.
  assign step = (time_step_q == '0) ? StepW'(1) : time_step_q;

  // Work on one axis at a time: magnitude and sign of the difference.
  assign diff = (ValW+1)'(new_q[axis_q]) - (ValW+1)'(prev_q[axis_q]);
  assign mag  = diff[ValW] ? ValW'(-diff) : diff[ValW-1:0];

  // Rounded quotient: (2*num + span) / (2*span).
  assign div_num   = {1'b0, prod_q, 1'b0} + NumW'(span_q);
  assign div_den   = {span_q, 1'b0};
  assign div_start = (state_q == ST_DSTART);

  assign interp = neg_q ? (ValW+1)'(prev_q[axis_q]) - (ValW+1)'({1'b0, div_quot})
                        : (ValW+1)'(prev_q[axis_q]) + (ValW+1)'({1'b0, div_quot});

  // End-of-run test for the point being loaded.
  assign next_off = {1'b0, off_q} + (TimeW+1)'(step);
  assign beyond   = (next_off > {1'b0, span_q});
  assign at_cap   = (cnt_q == CntW'(MaxPoints - 1));

  lirs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      time_step_q <= StepReset;
      prev_time_q <= '0;
      have_prev_q <= 1'b0;
      span_q      <= '0;
      off_q       <= '0;
      cnt_q       <= '0;
      axis_q      <= '0;
      prod_q      <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pt_time_q   <= '0;
      last_q      <= 1'b0;
      capped_q    <= 1'b0;
      for (int i = 0; i < NumAxes; i++) begin
        prev_q[i]   <= '0;
        new_q[i]    <= '0;
        res_q[i]    <= '0;
        pt_val_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        time_step_q <= cfg_wdata_i;
      end

      // Drop the output beat once taken; in ST_LOAD the load refills it.
      if (out_valid_q && !out_stall_i && (state_q != ST_LOAD)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            have_prev_q <= 1'b1;
            if (have_prev_q && (sample_time_i > prev_time_q)) begin
              // Start a run; hold the old sample until the run ends.
              span_q <= sample_time_i - prev_time_q;
              off_q  <= '0;
              cnt_q  <= '0;
              axis_q <= '0;
              for (int i = 0; i < NumAxes; i++) begin
                new_q[i] <= in_val[i];
              end
              state_q <= ST_MUL;
            end else begin
              prev_time_q <= sample_time_i;
              for (int i = 0; i < NumAxes; i++) begin
                prev_q[i] <= in_val[i];
              end
            end
          end
        end

        ST_MUL: begin
          prod_q  <= ProdW'(mag) * ProdW'(off_q);
          neg_q   <= diff[ValW];
          state_q <= ST_DSTART;
        end

        ST_DSTART: begin
          state_q <= ST_DWAIT;
        end

        ST_DWAIT: begin
          if (div_done) begin
            res_q[axis_q] <= interp[ValW-1:0];
            if (axis_q == AxisLast) begin
              state_q <= ST_LOAD;
            end else begin
              axis_q  <= axis_q + 1'b1;
              state_q <= ST_MUL;
            end
          end
        end

        ST_LOAD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            pt_time_q   <= prev_time_q + off_q;
            for (int i = 0; i < NumAxes; i++) begin
              pt_val_q[i] <= res_q[i];
            end
            last_q   <= beyond || at_cap;
            capped_q <= at_cap && !beyond;
            if (beyond || at_cap) begin
              // Run done: the new sample becomes the stored one.
              prev_time_q <= prev_time_q + span_q;
              for (int i = 0; i < NumAxes; i++) begin
                prev_q[i] <= new_q[i];
              end
              state_q <= ST_IDLE;
            end else begin
              off_q   <= next_off[TimeW-1:0];
              cnt_q   <= cnt_q + 1'b1;
              axis_q  <= '0;
              state_q <= ST_MUL;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign point_time_o = pt_time_q;
  assign point_x_o    = pt_val_q[0];
  assign point_y_o    = pt_val_q[1];
  assign point_z_o    = pt_val_q[2];
  assign last_point_o = last_q;
  assign capped_o     = capped_q;

endmodule

>>> rtl/lirs_checker.sv
// ----------------------------------------------------------------------------
// lirs_checker
// Port-level checks for the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lirs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [lirs_pkg::TimeW-1:0]  point_time_o,
  input logic                        last_point_o,
  input logic                        capped_o
);
  import lirs_pkg::*;

  // A stalled beat stays valid and holds its timestamp.
  `LIRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `LIRS_ASSERT_NEXT(a_time_hold, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(point_time_o))

  // A capped run ends on that point.
  `LIRS_ASSERT_IMPLY(a_cap_last, clk_i, rst_ni, out_valid_o && capped_o, last_point_o)

  // While a run still has points to come, no new sample is taken.
  `LIRS_ASSERT_IMPLY(a_run_busy, clk_i, rst_ni, out_valid_o && !last_point_o, in_stall_o)

endmodule

bind linear_interpolating_resampler_core lirs_checker u_lirs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .point_time_o (point_time_o),
  .last_point_o (last_point_o),
  .capped_o     (capped_o)
);
